// File: rtl/core/scfl_pkg.sv
// shared types and constants for the size class free list pool
// request and response beat structs, work item passed from front to back
// no dependencies
`default_nettype none

package scfl_pkg;

    localparam int NUM_CLASSES_DEF = 8;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int MIN_BLOCK_DEF   = 32;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int CLASS_W     = 4;
    localparam int CAP_W       = 9;
    localparam int TAG_W       = 13;
    localparam int FIELD_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [2:0] {
        STAT_HIT          = 3'd0,
        STAT_MISS         = 3'd1,
        STAT_OUT_ALLOC    = 3'd2,
        STAT_PUSHED       = 3'd3,
        STAT_FREE_BACKING = 3'd4,
        STAT_NULL         = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        KIND_ALLOC_POOL,
        KIND_ALLOC_OUT,
        KIND_FREE_PUSH,
        KIND_FREE_BACKING,
        KIND_FREE_NULL
    } kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } back_state_t;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] block_addr;
        logic [TAG_W-1:0]   block_tag;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [FIELD_W-1:0] out_addr;
        logic [TAG_W-1:0]   out_tag;
        logic [FIELD_W-1:0] backing_size;
    } rsp_t;

    // size holds the rounded class size, or the raw size for an out-of-pool alloc
    typedef struct packed {
        kind_t              kind;
        logic [CLASS_W-1:0] cls;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] addr;
    } work_t;

endpackage

`default_nettype wire

// File: rtl/core/size_class_free_list_pool.sv
// top level of the size class free list pool
// ties front, work queue and back together; uses scfl_pkg
//
// request beats come in on req, taken at a clock edge where start is high
// and busy is low. each request gives exactly one response beat on result,
// marked by done for one cycle; the receiver cannot stall, so the block
// never holds a response back.
// depth_cap is to be written through cfg_we / cfg_wdata only while the
// block is idle, which the block itself does not enforce. a beat passes the
// front register, a queue slot and the result register on its way to done;
// a pool hit also reads the stack memory through its registered read port.
// throughput: the back end retires one beat per cycle, save that a pool hit
// also holds it in the pop state; the front register and two-entry queue let
// requests flow as the back end works; busy rises only when both are full.
// reset clears the per-class counts, the queue and sets depth_cap to 256;
// the stack memory is not cleared, an entry is read only after a push
// wrote it, so no clearing pass is needed and requests are taken right
// after reset.
`default_nettype none

module size_class_free_list_pool #(
    parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = scfl_pkg::STACK_DEPTH_DEF,
    parameter int MIN_BLOCK   = scfl_pkg::MIN_BLOCK_DEF,
    parameter int ADDR_WIDTH  = scfl_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire scfl_pkg::req_t             req,
    output logic                            busy,
    input  wire logic                       cfg_we,
    input  wire logic [scfl_pkg::CAP_W-1:0] cfg_wdata,
    output logic                            done,
    output scfl_pkg::rsp_t                  result
);
    import scfl_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             q_full;
    logic             q_push;
    work_t            q_wdata;
    logic             q_valid;
    logic             q_pop;
    work_t            q_rdata;

    assign cap_next = cfg_we ? cfg_wdata : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    scfl_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .MIN_BLOCK   (MIN_BLOCK),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    scfl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    scfl_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cap     (cap_reg),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

    a_busy_only_when_queue_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        busy |-> q_full
    ) else $error("busy raised while the queue has room");

    a_no_push_into_full_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full
    ) else $error("work item pushed into a full queue");

    a_addr_only_on_hit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_HIT) |-> (result.out_addr == '0)
    ) else $error("address on a beat that is not a pool hit");

    a_hit_after_pop_cycle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.status == STAT_HIT) |-> !$past(done)
    ) else $error("pool hit without its memory read cycle");

endmodule

`default_nettype wire

// File: rtl/core/scfl_front.sv
// front end: takes request beats, finds the size class and the kind of work
// holds one classified item until the queue has room; uses scfl_pkg
`default_nettype none

module scfl_front #(
    parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK   = scfl_pkg::MIN_BLOCK_DEF,
    parameter int ADDR_WIDTH  = scfl_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire scfl_pkg::req_t req,
    output logic               busy,
    input  wire logic          q_full,
    output logic               q_push,
    output scfl_pkg::work_t    q_wdata
);
    import scfl_pkg::*;

    localparam logic [63:0] MAX_BLOCK = 64'(MIN_BLOCK) << (NUM_CLASSES - 1);

    logic  valid_reg;
    logic  valid_next;
    work_t work_reg;
    work_t work_next;
    logic  accept;

    assign busy   = valid_reg && q_full;
    assign q_push = valid_reg && !q_full;
    assign accept = start && !busy;
    assign q_wdata = work_reg;

    // class search over independent bound compares
    always_comb
    begin
        logic [FIELD_W-1:0]    val;
        logic [CLASS_W-1:0]    cls;
        logic [FIELD_W-1:0]    rounded;
        logic [63:0]           bound;
        logic [ADDR_WIDTH-1:0] addr_m;
        val     = req.action ? FIELD_W'(req.block_tag) : req.request_size;
        cls     = CLASS_W'(NUM_CLASSES - 1);
        rounded = FIELD_W'(MAX_BLOCK);
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            bound = 64'(MIN_BLOCK) << i;
            if (64'(val) <= bound)
            begin
                cls     = CLASS_W'(i);
                rounded = FIELD_W'(bound);
            end
        end
        addr_m         = ADDR_WIDTH'(req.block_addr);
        work_next.cls  = cls;
        work_next.addr = req.block_addr;
        work_next.size = rounded;
        if (!req.action)
        begin
            if (64'(val) < 64'(MIN_BLOCK) || 64'(val) > MAX_BLOCK)
            begin
                work_next.kind = KIND_ALLOC_OUT;
                work_next.size = req.request_size;
            end
            else
            begin
                work_next.kind = KIND_ALLOC_POOL;
            end
        end
        else if (addr_m == '0)
        begin
            work_next.kind = KIND_FREE_NULL;
        end
        else if (val == '0 || 64'(val) > MAX_BLOCK)
        begin
            work_next.kind = KIND_FREE_BACKING;
        end
        else
        begin
            work_next.kind = KIND_FREE_PUSH;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scfl_queue.sv
// two-entry fifo of classified work items between front and back
// uses scfl_pkg
`default_nettype none

module scfl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire scfl_pkg::work_t wdata,
    input  wire logic            pop,
    output logic                 full,
    output logic                 valid,
    output scfl_pkg::work_t      rdata
);
    import scfl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scfl_back.sv
// back end: per-class entry counts and the free address stack memory
// performs push and pop, drives the result beat; uses scfl_pkg
`default_nettype none

module scfl_back #(
    parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = scfl_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_WIDTH  = scfl_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [scfl_pkg::CAP_W-1:0] cap,
    input  wire logic                       q_valid,
    input  wire scfl_pkg::work_t            q_rdata,
    output logic                            q_pop,
    output logic                            done,
    output scfl_pkg::rsp_t                  result
);
    import scfl_pkg::*;

    localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [CNT_W-1:0]      count_reg [NUM_CLASSES];
    logic [ADDR_WIDTH-1:0] mem [MEM_DEPTH];
    logic [ADDR_WIDTH-1:0] rd_data_reg;
    logic [TAG_W-1:0]      pend_tag_reg;
    logic [TAG_W-1:0]      pend_tag_next;
    rsp_t                  result_reg;
    rsp_t                  result_next;
    logic                  done_reg;
    logic                  done_next;

    logic [CLS_IDX_W-1:0]  cls_idx;
    logic [CNT_W-1:0]      cnt_cur;
    logic                  cnt_we;
    logic [CNT_W-1:0]      cnt_wdata;
    logic                  mem_we;
    logic                  mem_re;
    logic [CNT_W-1:0]      slot;
    logic [MEM_AW-1:0]     mem_addr;
    logic                  can_pop;
    logic                  can_push;

    assign cls_idx  = q_rdata.cls[CLS_IDX_W-1:0];
    assign cnt_cur  = count_reg[cls_idx];
    assign can_pop  = (cnt_cur != '0);
    assign can_push = (32'(cnt_cur) < 32'(cap)) && (32'(cnt_cur) < STACK_DEPTH);
    assign slot     = (q_rdata.kind == KIND_FREE_PUSH) ? cnt_cur : cnt_cur - 1'b1;
    assign mem_addr = MEM_AW'(32'(cls_idx) * 32'(STACK_DEPTH) + 32'(slot));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_rdata.kind == KIND_ALLOC_POOL && can_pop)
                begin
                    state_next = BK_POP;
                end
            end
            BK_POP:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        cnt_we        = 1'b0;
        cnt_wdata     = cnt_cur;
        done_next     = 1'b0;
        pend_tag_next = pend_tag_reg;
        result_next   = result_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop                    = 1'b1;
                    result_next.status       = STAT_NULL;
                    result_next.out_addr     = '0;
                    result_next.out_tag      = '0;
                    result_next.backing_size = '0;
                    case (q_rdata.kind)
                        KIND_ALLOC_POOL:
                        begin
                            if (can_pop)
                            begin
                                mem_re        = 1'b1;
                                cnt_we        = 1'b1;
                                cnt_wdata     = cnt_cur - 1'b1;
                                pend_tag_next = q_rdata.size[TAG_W-1:0];
                            end
                            else
                            begin
                                done_next                = 1'b1;
                                result_next.status       = STAT_MISS;
                                result_next.out_tag      = q_rdata.size[TAG_W-1:0];
                                result_next.backing_size = q_rdata.size;
                            end
                        end
                        KIND_ALLOC_OUT:
                        begin
                            done_next                = 1'b1;
                            result_next.status       = STAT_OUT_ALLOC;
                            result_next.backing_size = q_rdata.size;
                        end
                        KIND_FREE_PUSH:
                        begin
                            done_next = 1'b1;
                            if (can_push)
                            begin
                                mem_we             = 1'b1;
                                cnt_we             = 1'b1;
                                cnt_wdata          = cnt_cur + 1'b1;
                                result_next.status = STAT_PUSHED;
                            end
                            else
                            begin
                                result_next.status = STAT_FREE_BACKING;
                            end
                        end
                        KIND_FREE_BACKING:
                        begin
                            done_next          = 1'b1;
                            result_next.status = STAT_FREE_BACKING;
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next.status = STAT_NULL;
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                done_next                = 1'b1;
                result_next.status       = STAT_HIT;
                result_next.out_addr     = FIELD_W'(rd_data_reg);
                result_next.out_tag      = pend_tag_reg;
                result_next.backing_size = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cnt_we)
            begin
                count_reg[cls_idx] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= ADDR_WIDTH'(q_rdata.addr);
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tag_reg <= pend_tag_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: tb/tb_size_class_free_list_pool.sv
// testbench for size_class_free_list_pool: directed corner beats, then random phases
// a shadow of the per-class stacks predicts each response; uses scfl_pkg
`timescale 1ns / 1ps

module tb_size_class_free_list_pool;

    import scfl_pkg::*;

    localparam int NUM_CLASSES = NUM_CLASSES_DEF;
    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int MIN_BLOCK   = MIN_BLOCK_DEF;
    localparam int MAX_BLOCK   = MIN_BLOCK << (NUM_CLASSES - 1);
    localparam int SETTLE      = 8;
    localparam int NUM_PHASES  = 7;

    class pool_shadow;
        logic [FIELD_W-1:0] cached_addr [NUM_CLASSES][STACK_DEPTH];
        int                 class_fill [NUM_CLASSES];
        int                 cap;
        rsp_t               due_rsp [$];
        int                 errors;
        int                 requests;
        int                 status_seen [6];

        function new();
            foreach (class_fill[i]) class_fill[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            cap      = int'(CAP_RESET);
            errors   = 0;
            requests = 0;
        endfunction

        function void set_cap(logic [CAP_W-1:0] value);
            cap = int'(value);
        endfunction

        function int outstanding();
            return due_rsp.size();
        endfunction

        // smallest class at least sz, NUM_CLASSES if none
        function int size_class(logic [FIELD_W-1:0] sz, output logic [FIELD_W-1:0] rounded);
            logic [FIELD_W-1:0] blk;
            int                 k;
            blk = FIELD_W'(MIN_BLOCK);
            k   = 0;
            while (blk < sz && k < NUM_CLASSES)
            begin
                blk = blk << 1;
                k++;
            end
            rounded = blk;
            return k;
        endfunction

        function void take_request(req_t r);
            rsp_t               e;
            int                 k;
            int                 limit;
            logic [FIELD_W-1:0] rounded;
            e     = '0;
            limit = (cap > STACK_DEPTH) ? STACK_DEPTH : cap;
            if (r.action == 1'b0)
            begin
                if (r.request_size < MIN_BLOCK || r.request_size > MAX_BLOCK)
                begin
                    e.status       = STAT_OUT_ALLOC;
                    e.backing_size = r.request_size;
                end
                else
                begin
                    k         = size_class(r.request_size, rounded);
                    e.out_tag = rounded[TAG_W-1:0];
                    if (class_fill[k] > 0)
                    begin
                        class_fill[k]--;
                        e.out_addr = cached_addr[k][class_fill[k]];
                        e.status   = STAT_HIT;
                    end
                    else
                    begin
                        e.status       = STAT_MISS;
                        e.backing_size = rounded;
                    end
                end
            end
            else
            begin
                if (r.block_addr == '0)
                    e.status = STAT_NULL;
                else if (r.block_tag == '0)
                    e.status = STAT_FREE_BACKING;
                else
                begin
                    k = size_class({{(FIELD_W-TAG_W){1'b0}}, r.block_tag}, rounded);
                    if (r.block_tag > MAX_BLOCK || k >= NUM_CLASSES)
                        e.status = STAT_FREE_BACKING;
                    else if (class_fill[k] < limit)
                    begin
                        cached_addr[k][class_fill[k]] = r.block_addr;
                        class_fill[k]++;
                        e.status = STAT_PUSHED;
                    end
                    else
                        e.status = STAT_FREE_BACKING;
                end
            end
            status_seen[e.status]++;
            requests++;
            due_rsp.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_response(rsp_t got);
            rsp_t e;
            if (due_rsp.size() == 0)
            begin
                report($sformatf("response with none due, status %0d", got.status));
                return;
            end
            e = due_rsp.pop_front();
            if (got.status !== e.status)
                report($sformatf("status got %0d want %0d", got.status, e.status));
            if (got.out_addr !== e.out_addr)
                report($sformatf("out_addr got %h want %h", got.out_addr, e.out_addr));
            if (got.out_tag !== e.out_tag)
                report($sformatf("out_tag got %0d want %0d", got.out_tag, e.out_tag));
            if (got.backing_size !== e.backing_size)
                report($sformatf("backing_size got %h want %h", got.backing_size,
                                 e.backing_size));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    req_t             req;
    logic             busy;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    logic             done;
    rsp_t             result;

    pool_shadow shadow;

    int phase_cap   [NUM_PHASES] = '{3, 1, 0, 511, 256, 40, 300};
    int phase_items [NUM_PHASES] = '{150, 120, 80, 360, 200, 150, 100};
    int phase_free  [NUM_PHASES] = '{55, 50, 50, 95, 35, 60, 50};
    int phase_focus [NUM_PHASES] = '{50, 50, 30, 95, 50, 60, 50};

    size_class_free_list_pool u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_response(result);
    end

    function automatic req_t make_alloc(logic [FIELD_W-1:0] size);
        req_t r;
        r              = '0;
        r.action       = 1'b0;
        r.request_size = size;
        r.block_addr   = $urandom;
        r.block_tag    = TAG_W'($urandom_range(0, 8191));
        return r;
    endfunction

    function automatic req_t make_free(logic [FIELD_W-1:0] addr, logic [TAG_W-1:0] tag);
        req_t r;
        r              = '0;
        r.action       = 1'b1;
        r.request_size = $urandom;
        r.block_addr   = addr;
        r.block_tag    = tag;
        return r;
    endfunction

    // mostly well-formed beats aimed at one busy class, the rest noise
    function automatic req_t random_request(int free_pct, int focus_pct, int focus);
        int                 k;
        int                 lo;
        int                 hi;
        logic [FIELD_W-1:0] addr;
        if ($urandom_range(0, 99) < 12)
        begin
            if ($urandom_range(0, 1))
                return make_alloc($urandom);
            addr = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
            return make_free(addr, TAG_W'($urandom_range(0, 8191)));
        end
        k  = ($urandom_range(0, 99) < focus_pct) ? focus : $urandom_range(0, NUM_CLASSES - 1);
        hi = MIN_BLOCK << k;
        lo = (k == 0) ? MIN_BLOCK : (hi / 2) + 1;
        if ($urandom_range(0, 99) >= free_pct)
            return make_alloc($urandom_range(0, 1) ? hi : $urandom_range(lo, hi));
        addr = $urandom & ~(hi - 1);
        if (addr == '0)
            addr = FIELD_W'(hi);
        if ($urandom_range(0, 3) != 0)
            return make_free(addr, TAG_W'(hi));
        if (k == 0)
            return make_free(addr, TAG_W'($urandom_range(1, MIN_BLOCK - 1)));
        return make_free(addr, TAG_W'($urandom_range(lo, hi)));
    endfunction

    // entered and left at a falling edge; start stays high when the next beat follows at once
    task automatic send_beat(input req_t r, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        shadow.take_request(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (shadow.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow.set_cap(value);
    endtask

    task automatic run_phase(input int count, input int free_pct, input int focus_pct);
        int focus;
        int gap;
        bit burst;
        focus = $urandom_range(0, NUM_CLASSES - 1);
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                burst = !burst;
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            gap = burst ? 0 : $urandom_range(0, 13);
            send_beat(random_request(free_pct, focus_pct, focus), gap);
        end
    endtask

    task automatic run_directed();
        req_t beats [$];
        beats.push_back(make_alloc(32'd0));
        beats.push_back(make_alloc(32'd31));
        beats.push_back(make_alloc(32'd32));
        beats.push_back(make_alloc(32'd4097));
        beats.push_back(make_alloc(32'hFFFF_FFFF));
        beats.push_back(make_alloc(32'd4096));
        beats.push_back(make_free(32'd0, 13'd64));
        beats.push_back(make_free(32'hFFFF_FFFF, 13'd0));
        beats.push_back(make_free(32'h0000_1000, 13'd1));
        beats.push_back(make_free(32'h0000_2000, 13'd32));
        beats.push_back(make_free(32'h0000_3000, 13'd100));
        beats.push_back(make_free(32'h0000_4000, 13'd4096));
        beats.push_back(make_free(32'h0000_5000, 13'd4097));
        beats.push_back(make_free(32'h0000_6000, 13'h1FFF));
        beats.push_back(make_alloc(32'd1));
        beats.push_back(make_alloc(32'd32));
        beats.push_back(make_alloc(32'd33));
        beats.push_back(make_alloc(32'd97));
        beats.push_back(make_alloc(32'd2049));
        beats.push_back(make_alloc(32'd32));
        beats.push_back(make_alloc(32'd32));
        beats.push_back(make_free(32'hFFFF_FFE0, 13'd4096));
        beats.push_back(make_alloc(32'd4096));
        beats.push_back(make_free(32'h8000_0000, 13'd0));
        foreach (beats[i])
            send_beat(beats[i], 0);
    endtask

    initial
    begin
        shadow    = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset cap, back to back
        run_directed();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_cap(CAP_W'(phase_cap[p]));
            run_phase(phase_items[p], phase_free[p], phase_focus[p]);
        end

        wait_drained();
        if (shadow.outstanding() != 0)
            shadow.report($sformatf("%0d responses never came", shadow.outstanding()));

        $display("covered %0d request beats under %0d depth cap settings",
                 shadow.requests, NUM_PHASES + 1);
        $display("hit %0d miss %0d out-of-pool %0d pushed %0d to backing %0d null %0d",
                 shadow.status_seen[STAT_HIT], shadow.status_seen[STAT_MISS],
                 shadow.status_seen[STAT_OUT_ALLOC], shadow.status_seen[STAT_PUSHED],
                 shadow.status_seen[STAT_FREE_BACKING], shadow.status_seen[STAT_NULL]);
        if (shadow.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: size_class_free_list_pool.f
rtl/core/scfl_pkg.sv
rtl/core/scfl_front.sv
rtl/core/scfl_queue.sv
rtl/core/scfl_back.sv
rtl/core/size_class_free_list_pool.sv
tb/tb_size_class_free_list_pool.sv
